>>> hw/rtl/fault_record_frame_parser_top_defines.svh
// ---------------------------------------------------------------------------
// Fault record frame parser assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FAULT_RECORD_FRAME_PARSER_TOP_DEFINES_SVH
`define FAULT_RECORD_FRAME_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define FRP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frp assertion failed");

// next-cycle implication
`define FRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frp assertion failed");

`endif

>>> hw/rtl/frp_pkg.sv
// ---------------------------------------------------------------------------
// Fault record frame parser package
// Result kinds, status codes, length limits and the emit record from the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package frp_pkg;

    localparam logic [1:0] KIND_COMP    = 2'd0;
    localparam logic [1:0] KIND_META    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_TRUNC   = 2'd2;

    localparam int          VARINT_MAX_BYTES = 10;
    localparam logic [32:0] COUNT_MAX        = 33'h1_FFFF_FFFF;
    localparam int          PREFIX_BYTES     = 4;

    // string length limits and the widths of their length fields
    localparam int MAX_COMPONENT_LEN = 64;
    localparam int MAX_META_LEN      = 256;
    localparam int CLEN_W            = $clog2(MAX_COMPONENT_LEN + 1);
    localparam int MLEN_W            = $clog2(MAX_META_LEN + 1);

    // what one accepted byte produces
    typedef struct packed {
        logic       has_text;
        logic [1:0] text_kind;
        logic [7:0] text_byte;
        logic       has_sum;
        logic [1:0] status;
    } t_emit;

endpackage

>>> hw/rtl/frp_if.sv
// ---------------------------------------------------------------------------
// Fault record frame parser channels
// Valid/ready channels for frame bytes in and result words out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface frp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface frp_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                item_kind;
    logic [7:0]                text_byte;
    logic [1:0]                parse_status;
    logic [31:0]               record_id;
    logic [7:0]                severity_code;
    logic [63:0]               timestamp_value;
    logic [frp_pkg::CLEN_W-1:0] component_length;
    logic                      meta_seen;
    logic [frp_pkg::MLEN_W-1:0] meta_length;
    logic                      run_last;

    modport source (
        output valid, output item_kind, output text_byte, output parse_status,
        output record_id, output severity_code, output timestamp_value,
        output component_length, output meta_seen, output meta_length,
        output run_last, input ready
    );
    modport sink (
        input valid, input item_kind, input text_byte, input parse_status,
        input record_id, input severity_code, input timestamp_value,
        input component_length, input meta_seen, input meta_length,
        input run_last, output ready
    );
endinterface

>>> hw/rtl/frp_parser.sv
// ---------------------------------------------------------------------------
// Fault record frame parser core
// Per-byte field state machine with varint assembly and summary status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module frp_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [7:0]                 i_byte,
    input  logic                       i_end,
    output frp_pkg::t_emit             o_emit,
    output logic [31:0]                o_id,
    output logic [7:0]                 o_sev,
    output logic [63:0]                o_ts,
    output logic [frp_pkg::CLEN_W-1:0] o_clen,
    output logic                       o_mflag,
    output logic [frp_pkg::MLEN_W-1:0] o_mlen
);
    import frp_pkg::*;

    localparam int REM_W = (CLEN_W > MLEN_W) ? CLEN_W : MLEN_W;

    localparam logic [3:0] PH_PREFIX = 4'd0;
    localparam logic [3:0] PH_CLEN   = 4'd1;
    localparam logic [3:0] PH_CBYTES = 4'd2;
    localparam logic [3:0] PH_ID     = 4'd3;
    localparam logic [3:0] PH_SEV    = 4'd4;
    localparam logic [3:0] PH_TS     = 4'd5;
    localparam logic [3:0] PH_TAG    = 4'd6;
    localparam logic [3:0] PH_MLEN   = 4'd7;
    localparam logic [3:0] PH_MBYTES = 4'd8;
    localparam logic [3:0] PH_DONE   = 4'd9;

    logic [3:0]        r_phase, n_phase;
    logic [32:0]       r_count, n_count;
    logic [31:0]       r_decl, n_decl;
    logic [63:0]       r_acc, n_acc;
    logic [3:0]        r_steps, n_steps;
    logic [REM_W-1:0]  r_remain, n_remain;
    logic [31:0]       r_id, n_id;
    logic [7:0]        r_sev, n_sev;
    logic [63:0]       r_ts, n_ts;
    logic [CLEN_W-1:0] r_clen, n_clen;
    logic [MLEN_W-1:0] r_mlen, n_mlen;
    logic              r_mflag, n_mflag;
    logic              r_err, n_err;

    logic [6:0]  v_shamt;
    logic [63:0] v_fed;
    logic        v_cont;
    logic        v_too_long;
    logic [1:0]  v_status;

    assign v_shamt    = 7'({3'd0, r_steps} * 7'd7);
    assign v_fed      = r_acc | ({57'd0, i_byte[6:0]} << v_shamt);
    assign v_cont     = i_byte[7];
    assign v_too_long = v_cont && (r_steps >= 4'(VARINT_MAX_BYTES - 1));

    always_comb begin
        n_phase  = r_phase;
        n_count  = (r_count != COUNT_MAX) ? r_count + 33'd1 : r_count;
        n_decl   = r_decl;
        n_acc    = r_acc;
        n_steps  = r_steps;
        n_remain = r_remain;
        n_id     = r_id;
        n_sev    = r_sev;
        n_ts     = r_ts;
        n_clen   = r_clen;
        n_mlen   = r_mlen;
        n_mflag  = r_mflag;
        n_err    = r_err;
        o_emit   = '0;

        if (r_phase == PH_PREFIX) begin
            n_decl = r_decl | ({24'd0, i_byte} << {r_count[1:0], 3'b000});
            if (r_count[1:0] == 2'(PREFIX_BYTES - 1)) begin
                n_phase = PH_CLEN;
                n_acc   = '0;
                n_steps = '0;
            end
        end else if (!r_err) begin
            unique case (r_phase) inside
                PH_CLEN, PH_MLEN: begin
                    if (v_too_long) begin
                        n_err = 1'b1;
                    end else if (v_cont) begin
                        n_acc   = v_fed;
                        n_steps = r_steps + 4'd1;
                    end else begin
                        n_acc   = '0;
                        n_steps = '0;
                        if (r_phase == PH_CLEN) begin
                            if (v_fed > 64'(MAX_COMPONENT_LEN)) begin
                                n_err = 1'b1;
                            end else begin
                                n_clen   = CLEN_W'(v_fed);
                                n_remain = REM_W'(v_fed);
                                n_phase  = (v_fed == '0) ? PH_ID : PH_CBYTES;
                            end
                        end else begin
                            if (v_fed > 64'(MAX_META_LEN)) begin
                                n_err = 1'b1;
                            end else begin
                                n_mlen   = MLEN_W'(v_fed);
                                n_remain = REM_W'(v_fed);
                                n_phase  = (v_fed == '0) ? PH_DONE : PH_MBYTES;
                            end
                        end
                    end
                end
                PH_CBYTES, PH_MBYTES: begin
                    o_emit.has_text  = 1'b1;
                    o_emit.text_kind = (r_phase == PH_CBYTES) ? KIND_COMP : KIND_META;
                    o_emit.text_byte = i_byte;
                    n_remain = r_remain - REM_W'(1);
                    if (r_remain == REM_W'(1)) begin
                        n_phase = (r_phase == PH_CBYTES) ? PH_ID : PH_DONE;
                    end
                end
                PH_ID: begin
                    if (v_too_long) begin
                        n_err = 1'b1;
                    end else if (v_cont) begin
                        n_acc   = v_fed;
                        n_steps = r_steps + 4'd1;
                    end else begin
                        n_acc   = '0;
                        n_steps = '0;
                        if (v_fed[63:32] != '0) begin
                            n_err = 1'b1;
                        end else begin
                            n_id    = v_fed[31:0];
                            n_phase = PH_SEV;
                        end
                    end
                end
                PH_SEV: begin
                    n_sev   = i_byte;
                    n_phase = PH_TS;
                    n_acc   = '0;
                    n_steps = '0;
                end
                PH_TS: begin
                    if (v_too_long) begin
                        n_err = 1'b1;
                    end else if (v_cont) begin
                        n_acc   = v_fed;
                        n_steps = r_steps + 4'd1;
                    end else begin
                        n_ts    = v_fed;
                        n_acc   = '0;
                        n_steps = '0;
                        n_phase = PH_TAG;
                    end
                end
                PH_TAG: begin
                    if (i_byte == 8'd0) begin
                        n_mflag = 1'b0;
                        n_mlen  = '0;
                        n_phase = PH_DONE;
                    end else if (i_byte == 8'd1) begin
                        n_mflag = 1'b1;
                        n_acc   = '0;
                        n_steps = '0;
                        n_phase = PH_MLEN;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    // done phase: any further byte is trailing garbage
                    n_err = 1'b1;
                end
            endcase
        end

        // summary looks at the state after this byte
        if (n_count < 33'(PREFIX_BYTES)) begin
            v_status = STATUS_INVALID;
        end else if ((n_count - 33'(PREFIX_BYTES)) != {1'b0, n_decl}) begin
            v_status = STATUS_INVALID;
        end else if (n_err) begin
            v_status = STATUS_INVALID;
        end else if (n_phase != PH_DONE) begin
            v_status = STATUS_TRUNC;
        end else begin
            v_status = STATUS_OK;
        end

        o_emit.has_sum = i_end;
        o_emit.status  = v_status;
        if (!i_take) begin
            o_emit = '0;
        end
    end

    assign o_id    = (v_status == STATUS_OK) ? n_id : '0;
    assign o_sev   = (v_status == STATUS_OK) ? n_sev : '0;
    assign o_ts    = (v_status == STATUS_OK) ? n_ts : '0;
    assign o_clen  = (v_status == STATUS_OK) ? n_clen : '0;
    assign o_mflag = (v_status == STATUS_OK) ? n_mflag : 1'b0;
    assign o_mlen  = (v_status == STATUS_OK) ? n_mlen : '0;

    // the end-of-frame byte returns everything to the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_end)) begin
            r_phase  <= PH_PREFIX;
            r_count  <= '0;
            r_decl   <= '0;
            r_acc    <= '0;
            r_steps  <= '0;
            r_remain <= '0;
            r_id     <= '0;
            r_sev    <= '0;
            r_ts     <= '0;
            r_clen   <= '0;
            r_mlen   <= '0;
            r_mflag  <= 1'b0;
            r_err    <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_decl   <= n_decl;
            r_acc    <= n_acc;
            r_steps  <= n_steps;
            r_remain <= n_remain;
            r_id     <= n_id;
            r_sev    <= n_sev;
            r_ts     <= n_ts;
            r_clen   <= n_clen;
            r_mlen   <= n_mlen;
            r_mflag  <= n_mflag;
            r_err    <= n_err;
        end
    end

endmodule

>>> hw/rtl/fault_record_frame_parser_top.sv
// ---------------------------------------------------------------------------
// Fault record frame parser
// Deframes length-prefixed fault records, streams string bytes, summarizes.
//
//   channel   dir  word
//   i_frame   in   frame_byte, frame_end
//   o_item    out  kind, text byte, status, decoded fields, run_last
//
// One byte is taken per cycle while ready; it is parsed in the cycle it is taken.
// A string byte that ends the frame gives two words; a three-word output
// queue absorbs them, and i_frame.ready follows its registered occupancy
// (ready while at most one word is queued).
// Output stalls back up into i_frame through that queue only.
// Synchronous active-low reset; no memories, no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fault_record_frame_parser_top_defines.svh"

module fault_record_frame_parser_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    frp_in_if.sink    i_frame,
    frp_out_if.source o_item
);
    import frp_pkg::*;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        text;
        logic [1:0]        status;
        logic [31:0]       id;
        logic [7:0]        sev;
        logic [63:0]       ts;
        logic [CLEN_W-1:0] clen;
        logic              mflag;
        logic [MLEN_W-1:0] mlen;
        logic              last;
    } t_entry;

    t_emit             emit;
    logic [31:0]       p_id;
    logic [7:0]        p_sev;
    logic [63:0]       p_ts;
    logic [CLEN_W-1:0] p_clen;
    logic              p_mflag;
    logic [MLEN_W-1:0] p_mlen;

    logic       take;
    logic       pop;
    logic [1:0] push_n;
    logic [1:0] cnt_p;
    t_entry     text_item, sum_item, item0, item1;
    t_entry     sh [3];
    t_entry     r_q [3];
    t_entry     n_q [3];
    logic [1:0] r_cnt, n_cnt;
    logic [2:0] fill_next;
    logic       head_sum;
    logic       head_bad;

    assign i_frame.ready = (r_cnt <= 2'd1);
    assign take          = i_frame.valid && i_frame.ready;

    frp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_frame.frame_byte),
        .i_end   (i_frame.frame_end),
        .o_emit  (emit),
        .o_id    (p_id),
        .o_sev   (p_sev),
        .o_ts    (p_ts),
        .o_clen  (p_clen),
        .o_mflag (p_mflag),
        .o_mlen  (p_mlen)
    );

    always_comb begin
        text_item      = '0;
        text_item.kind = emit.text_kind;
        text_item.text = emit.text_byte;
        text_item.last = !emit.has_sum;

        sum_item        = '0;
        sum_item.kind   = KIND_SUMMARY;
        sum_item.status = emit.status;
        sum_item.id     = p_id;
        sum_item.sev    = p_sev;
        sum_item.ts     = p_ts;
        sum_item.clen   = p_clen;
        sum_item.mflag  = p_mflag;
        sum_item.mlen   = p_mlen;
        sum_item.last   = 1'b1;

        item0  = emit.has_text ? text_item : sum_item;
        item1  = sum_item;
        push_n = {1'b0, emit.has_text} + {1'b0, emit.has_sum};
    end

    assign pop   = (r_cnt != 2'd0) && o_item.ready;
    assign cnt_p = r_cnt - {1'b0, pop};
    assign n_cnt = cnt_p + push_n;

    // shift queue: head at slot 0, new words land just past the survivors
    always_comb begin
        sh[0] = pop ? r_q[1] : r_q[0];
        sh[1] = pop ? r_q[2] : r_q[1];
        sh[2] = r_q[2];
        for (int i = 0; i < 3; i++) begin
            n_q[i] = sh[i];
            if ((push_n != 2'd0) && (2'(i) == cnt_p)) begin
                n_q[i] = item0;
            end else if ((push_n == 2'd2) && (2'(i) == cnt_p + 2'd1)) begin
                n_q[i] = item1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_item.valid            = (r_cnt != 2'd0);
    assign o_item.item_kind        = r_q[0].kind;
    assign o_item.text_byte        = r_q[0].text;
    assign o_item.parse_status     = r_q[0].status;
    assign o_item.record_id        = r_q[0].id;
    assign o_item.severity_code    = r_q[0].sev;
    assign o_item.timestamp_value  = r_q[0].ts;
    assign o_item.component_length = r_q[0].clen;
    assign o_item.meta_seen        = r_q[0].mflag;
    assign o_item.meta_length      = r_q[0].mlen;
    assign o_item.run_last         = r_q[0].last;

    assign fill_next = {1'b0, r_cnt} + {1'b0, push_n};
    assign head_sum  = (r_cnt != 2'd0) && (r_q[0].kind == KIND_SUMMARY);
    assign head_bad  = head_sum && (r_q[0].status != STATUS_OK);

    `FRP_ASSERT_IMPL(a_queue_no_overflow, take, fill_next <= 3'd3)
    `FRP_ASSERT_IMPL(a_summary_is_last, head_sum, r_q[0].last)
    `FRP_ASSERT_IMPL(a_bad_summary_zero, head_bad, (r_q[0].id == '0) && (r_q[0].ts == '0) && !r_q[0].mflag)
    `FRP_ASSERT_NEXT(a_pop_drains, pop && !take, r_cnt == $past(r_cnt) - 2'd1)

endmodule
